// ----- src/tcp_pkg.sv -----
// Shared constants for the triangle centroid and perimeter pipeline.
// Depends on nothing; every other file of the block depends on it.
package tcp_pkg;

  // Field widths of the coordinate and perimeter words.
  localparam int COORD_W = 16;
  localparam int PERIM_W = 19;

  // Absolute coordinate difference, its square and the sum of two squares.
  localparam int DIFF_W = COORD_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int RAD_W  = SQ_W + 1;

  // Floor square root of a RAD_W-bit radicand; one root bit per stage.
  localparam int ROOT_W = (RAD_W + 1) / 2;

  // Coordinate sum of three vertices and its magnitude plus one.
  localparam int SUM_W = COORD_W + 2;
  localparam int MAG_W = SUM_W - 1;

  // Division by three as a multiply by ceil(2^19 / 3) and a shift by 19.
  // Exact for every magnitude below 2^17.
  localparam int DIV3_SHIFT            = 19;
  localparam int RECIP_W               = 18;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 18'd174763;
  localparam int PROD_W                = MAG_W + RECIP_W;

  // Front stages, root stages and the final perimeter add.
  localparam int FRONT_N = 3;
  localparam int STG_N   = FRONT_N + ROOT_W + 1;
  localparam int STG_IW  = $clog2(STG_N);

endpackage

// ----- src/tcp_if.sv -----
// Valid/ready channel interfaces for triangle words and result words.
// Depends on tcp_pkg for field widths.
interface tcp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tcp_pkg::COORD_W-1:0]  first_x;
  logic signed [tcp_pkg::COORD_W-1:0]  first_y;
  logic signed [tcp_pkg::COORD_W-1:0]  second_x;
  logic signed [tcp_pkg::COORD_W-1:0]  second_y;
  logic signed [tcp_pkg::COORD_W-1:0]  third_x;
  logic signed [tcp_pkg::COORD_W-1:0]  third_y;

  modport source (
    output valid, first_x, first_y, second_x, second_y, third_x, third_y,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, second_x, second_y, third_x, third_y,
    output ready
  );
endinterface

interface tcp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tcp_pkg::COORD_W-1:0]  center_x;
  logic signed [tcp_pkg::COORD_W-1:0]  center_y;
  logic        [tcp_pkg::PERIM_W-1:0]  perimeter_len;

  modport source (
    output valid, center_x, center_y, perimeter_len,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, perimeter_len,
    output ready
  );
endinterface

// ----- src/triangle_centroid_perimeter.sv -----
// Triangle centroid and perimeter: top level of the streaming pipeline.
// Depends on tcp_pkg, the channel interfaces in tcp_if and tcp_isqrt.
//
// Usage:
//   item   (sink)   one triangle per word: three vertices, signed Q8.8.
//   result (source) one word per triangle: centroid x and y, signed Q8.8,
//                   rounded to nearest, and the perimeter as the sum of the
//                   three floored edge lengths, unsigned Q11.8.
// An accepted triangle passes three front stages (differences and sums,
// squares, radicands and the divide by three), seventeen root stages that
// each settle one bit of the square root, and the final perimeter add.
// A new triangle is taken every cycle unless a stalled receiver has filled
// every stage. Every stage holds its own valid bit and advances whenever it
// is empty or its successor advances, so a stalled receiver only holds the
// words that are blocked; bubbles close up and item.ready stays high while
// any stage is empty. Reset clears all valid bits; words in flight are
// dropped and result.valid is low in the first cycle after reset.
module triangle_centroid_perimeter (
  input  logic      clk,
  input  logic      rst,
  tcp_in_if.sink    item,
  tcp_out_if.source result
);
  import tcp_pkg::*;

  localparam int CEN_N = ROOT_W + 1;
  localparam int MID   = STG_N / 2;

  // Absolute difference of two coordinates.
  function automatic logic [DIFF_W-1:0] abs_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] d;
    d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
    return d[COORD_W] ? DIFF_W'(-d) : d[DIFF_W-1:0];
  endfunction

  // Magnitude of a coordinate sum plus one, the dividend of rounding by 3.
  function automatic logic [MAG_W-1:0] mag_plus1(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] m;
    m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    return MAG_W'(m + SUM_W'(1));
  endfunction

  // Stage valid bits and advance enables.
  logic [STG_N-1:0] vld;
  logic [STG_N-1:0] stg_en;

  // Stage 0: edge differences and coordinate sums.
  logic [DIFF_W-1:0]       a_dx [3];
  logic [DIFF_W-1:0]       a_dy [3];
  logic signed [SUM_W-1:0] a_sx;
  logic signed [SUM_W-1:0] a_sy;

  // Stage 1: squares and centroid dividends.
  logic [SQ_W-1:0]  b_sqx [3];
  logic [SQ_W-1:0]  b_sqy [3];
  logic [MAG_W-1:0] b_magx;
  logic [MAG_W-1:0] b_magy;
  logic             b_negx;
  logic             b_negy;

  // Stage 2: radicands and centroid quotients.
  logic [RAD_W-1:0]   c_rad [3];
  logic [COORD_W-1:0] c_qx;
  logic [COORD_W-1:0] c_qy;
  logic               c_negx;
  logic               c_negy;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;

  // Centroid shift line from stage 3 to the output stage.
  logic signed [COORD_W-1:0] cen_x [CEN_N];
  logic signed [COORD_W-1:0] cen_y [CEN_N];

  logic [ROOT_W-1:0]  edge_root [3];
  logic [PERIM_W-1:0] perim;

  // A stage moves on when it is empty or its successor moves on.
  always_comb begin
    stg_en[STG_N-1] = !vld[STG_N-1] || result.ready;
    for (int i = STG_N - 2; i >= 0; i--) begin
      stg_en[i] = !vld[i] || stg_en[i+1];
    end
  end

  assign item.ready = stg_en[0];

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stg_en[0]) begin
        vld[0] <= item.valid;
      end
      for (int i = 1; i < STG_N; i++) begin
        if (stg_en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: edges run first to second, second to third, third to first.
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      a_dx[0] <= abs_diff(item.first_x,  item.second_x);
      a_dy[0] <= abs_diff(item.first_y,  item.second_y);
      a_dx[1] <= abs_diff(item.second_x, item.third_x);
      a_dy[1] <= abs_diff(item.second_y, item.third_y);
      a_dx[2] <= abs_diff(item.third_x,  item.first_x);
      a_dy[2] <= abs_diff(item.third_y,  item.first_y);
      a_sx <= SUM_W'(item.first_x) + SUM_W'(item.second_x) + SUM_W'(item.third_x);
      a_sy <= SUM_W'(item.first_y) + SUM_W'(item.second_y) + SUM_W'(item.third_y);
    end
  end

  // Stage 1: square each difference; split the sums into sign and magnitude.
  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      for (int e = 0; e < 3; e++) begin
        b_sqx[e] <= SQ_W'(a_dx[e]) * SQ_W'(a_dx[e]);
        b_sqy[e] <= SQ_W'(a_dy[e]) * SQ_W'(a_dy[e]);
      end
      b_magx <= mag_plus1(a_sx);
      b_magy <= mag_plus1(a_sy);
      b_negx <= a_sx[SUM_W-1];
      b_negy <= a_sy[SUM_W-1];
    end
  end

  // Stage 2: sum of squares; floor((|s| + 1) / 3) by reciprocal multiply.
  assign prod_x = PROD_W'(b_magx) * PROD_W'(DIV3_RECIP);
  assign prod_y = PROD_W'(b_magy) * PROD_W'(DIV3_RECIP);

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      for (int e = 0; e < 3; e++) begin
        c_rad[e] <= RAD_W'(b_sqx[e]) + RAD_W'(b_sqy[e]);
      end
      c_qx   <= prod_x[DIV3_SHIFT +: COORD_W];
      c_qy   <= prod_y[DIV3_SHIFT +: COORD_W];
      c_negx <= b_negx;
      c_negy <= b_negy;
    end
  end

  // Square roots of the three radicands, stages 3 through 19.
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_edge
      tcp_isqrt u_isqrt (
        .clk      (clk),
        .en       (stg_en[FRONT_N +: ROOT_W]),
        .radicand (c_rad[g]),
        .root     (edge_root[g])
      );
    end
  endgenerate

  // Centroid: restore the sign at stage 3, then ride along with the roots.
  always_ff @(posedge clk) begin
    if (stg_en[FRONT_N]) begin
      cen_x[0] <= c_negx ? COORD_W'(-c_qx) : c_qx;
      cen_y[0] <= c_negy ? COORD_W'(-c_qy) : c_qy;
    end
    for (int j = 1; j < CEN_N; j++) begin
      if (stg_en[FRONT_N + j]) begin
        cen_x[j] <= cen_x[j-1];
        cen_y[j] <= cen_y[j-1];
      end
    end
  end

  // Output stage: sum the edge lengths of the triangle.
  always_ff @(posedge clk) begin
    if (stg_en[STG_N-1]) begin
      perim <= PERIM_W'(edge_root[0]) + PERIM_W'(edge_root[1])
             + PERIM_W'(edge_root[2]);
    end
  end

  assign result.valid         = vld[STG_N-1];
  assign result.center_x      = cen_x[CEN_N-1];
  assign result.center_y      = cen_y[CEN_N-1];
  assign result.perimeter_len = perim;

`ifndef SYNTH
  // An empty output stage always leaves room for a new triangle.
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !vld[STG_N-1] |-> item.ready)
    else $error("item.ready low while the output stage is empty");

  // An accepted triangle occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> vld[0])
    else $error("accepted triangle missing from stage 0");

  // A blocked middle stage keeps its word.
  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[MID] && !stg_en[MID]) |=> vld[MID])
    else $error("blocked middle stage lost its word");

  // Reset leaves no result word behind.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result.valid high after reset");
`endif

endmodule

// ----- src/tcp_isqrt.sv -----
// Pipelined floor integer square root, one result bit per register stage.
// Depends on tcp_pkg; stage enables come from the owner's valid pipeline.
module tcp_isqrt (
  input  logic                         clk,
  input  logic [tcp_pkg::ROOT_W-1:0]   en,
  input  logic [tcp_pkg::RAD_W-1:0]    radicand,
  output logic [tcp_pkg::ROOT_W-1:0]   root
);
  import tcp_pkg::*;

  // Trial values need two bits above the radicand.
  localparam int TRY_W = RAD_W + 2;

  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  genvar j;
  generate
    for (j = 0; j < ROOT_W; j++) begin : g_step
      localparam int K = ROOT_W - 1 - j;

      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [TRY_W-1:0]  trial;

      // Stage zero starts from the radicand with an empty root.
      if (j == 0) begin : g_first
        assign rem_in  = radicand;
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = rem_q[j-1];
        assign root_in = root_q[j-1];
      end

      // Setting bit K grows the square by 2^(K+1)*root + 2^(2K).
      assign trial = (TRY_W'(root_in) << (K + 1)) + (TRY_W'(1) << (2 * K));

      // Keep the bit when the remainder still covers the growth.
      always_ff @(posedge clk) begin
        if (en[j]) begin
          if (TRY_W'(rem_in) >= trial) begin
            rem_q[j]  <= rem_in - trial[RAD_W-1:0];
            root_q[j] <= root_in | (ROOT_W'(1) << K);
          end else begin
            rem_q[j]  <= rem_in;
            root_q[j] <= root_in;
          end
        end
      end
    end
  endgenerate

  assign root = root_q[ROOT_W-1];

endmodule
